// ===== hw/rtl/box_blur_separable_macros.svh =====
// Assertion shorthands for the blur block. Both expect clk_i and rst_ni in scope.
`ifndef BOX_BLUR_SEPARABLE_MACROS_SVH
`define BOX_BLUR_SEPARABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bbs_pkg.sv =====
`default_nettype none
package bbs_pkg;

  localparam int MAX_RADIUS    = 7;
  localparam int WIN           = 2 * MAX_RADIUS + 1;
  localparam int MAX_WIDTH_DEF = 1024;

  localparam int PIX_W  = 8;
  localparam int COL_W  = 10;
  localparam int ROW_W  = 12;
  localparam int RAD_W  = 3;
  localparam int WID_W  = 11;
  localparam int HGT_W  = 12;
  localparam int HSUM_W = 12;
  localparam int ACC_W  = 16;
  localparam int CFG_W  = 12;

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HSUM,
    ST_HWR,
    ST_VRD,
    ST_VADD,
    ST_DIV,
    ST_OUT
  } bbs_state_e;

  // Remainder modulo 15: base-16 digits are congruent to themselves mod 15.
  function automatic logic [3:0] mod15(input logic [11:0] v);
    logic [5:0] t;
    logic [4:0] f;
    t = 6'(v[3:0]) + 6'(v[7:4]) + 6'(v[11:8]);
    f = 5'(t[3:0]) + 5'(t[5:4]);
    return (f >= 5'd15) ? 4'(f - 5'd15) : f[3:0];
  endfunction

  // Kernel area (2r+1)^2.
  function automatic logic [7:0] area_of(input logic [2:0] r);
    logic [3:0] d;
    d = {r, 1'b1};
    return 8'(d) * 8'(d);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bbs_pix_if.sv =====
`default_nettype none
interface bbs_pix_if;
  logic                       valid;
  logic                       ready;
  logic [bbs_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bbs_res_if.sv =====
`default_nettype none
interface bbs_res_if;
  logic                       valid;
  logic                       ready;
  logic [bbs_pkg::PIX_W-1:0]  pixel_out;
  logic [bbs_pkg::COL_W-1:0]  out_col;
  logic [bbs_pkg::ROW_W-1:0]  out_row;
  logic                       run_last;
  logic                       frame_last;

  modport source (output valid, output pixel_out, output out_col, output out_row,
                  output run_last, output frame_last, input ready);
  modport sink   (input valid, input pixel_out, input out_col, input out_row,
                  input run_last, input frame_last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bbs_ram.sv =====
`default_nettype none
module bbs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/box_blur_separable.sv =====
// Channel  | Dir | Modport | Payload
// pix_i    | in  | sink    | pixel_in (8b), one source pixel in raster order
// res_o    | out | source  | pixel_out, out_col, out_row, run_last, frame_last
// cfg_*    | in  | write   | cfg_idx_i selects radius, image_width or image_height
//
// A request that closes no horizontal window leaves the block idle again. Otherwise each
// finished horizontal sum is written to the row store, and each result takes a read and an
// add per vertical tap, the division and a load of the result register, on one shared adder
// and one RAM read port. A result waits in the output state for as long as the result
// register is held by the sink.
// Reset clears the counters and control; the row store needs no clearing pass.
// A waiting result sits in its own register, so work goes on meanwhile; a new pixel is taken only when idle.
`default_nettype none
`include "box_blur_separable_macros.svh"
module box_blur_separable #(
  parameter int MAX_WIDTH = bbs_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [bbs_pkg::CFG_W-1:0] cfg_wdata_i,
  bbs_pix_if.sink                   pix_i,
  bbs_res_if.source                 res_o
);

  localparam int DEPTH = bbs_pkg::WIN * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  // The row store holds one horizontal sum per column for the last WIN rows.
  function automatic logic [AW-1:0] st_addr(input logic [3:0] slot,
                                            input logic [bbs_pkg::WID_W-1:0] x);
    return AW'(slot) * AW'(MAX_WIDTH) + AW'(x);
  endfunction

  function automatic logic [13:0] k_lo(input logic [11:0] p, input logic [2:0] r);
    return 14'(p) - 14'(r);
  endfunction

  function automatic logic [13:0] k_hi(input logic [11:0] p, input logic [2:0] r);
    return 14'(p) + 14'(r);
  endfunction

  // Configuration.
  logic [bbs_pkg::RAD_W-1:0] radius_q;
  logic [bbs_pkg::WID_W-1:0] width_q;
  logic [bbs_pkg::HGT_W-1:0] height_q;

  // Position of the next source pixel.
  logic [bbs_pkg::WID_W-1:0] col_q, col_d;
  logic [bbs_pkg::ROW_W-1:0] row_q, row_d;

  bbs_pkg::bbs_state_e state_q, state_d;

  // Per-request working registers.
  logic [2:0]                r_cur_q, r_cur_d;
  logic [bbs_pkg::WID_W-1:0] wl_q, wl_d, xlo_q, xlo_d, xhi_q, xhi_d, x_q, x_d;
  logic [bbs_pkg::ROW_W-1:0] hl_q, hl_d, ylo_q, ylo_d, yhi_q, yhi_d, y_q, y_d;
  logic [3:0]                hslot_q, hslot_d;
  logic                      have_y_q, have_y_d;
  logic [13:0]               k_q, k_d, kend_q, kend_d;
  logic [bbs_pkg::ACC_W-1:0] acc_q, acc_d, div_q, div_d;
  logic [2:0]                dcnt_q, dcnt_d;
  logic [7:0]                quo_q, quo_d;
  logic                      rd_pend_q, rd_pend_d;

  logic [bbs_pkg::PIX_W-1:0] win_q [bbs_pkg::WIN];

  // Result register.
  logic                      res_valid_q, res_valid_d;
  logic                      res_load;
  logic [bbs_pkg::PIX_W-1:0] res_pix_q;
  logic [bbs_pkg::COL_W-1:0] res_col_q;
  logic [bbs_pkg::ROW_W-1:0] res_row_q;
  logic                      res_rl_q, res_fl_q;

  // Row store port.
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [bbs_pkg::HSUM_W-1:0] ram_rdata;

  // Effective frame geometry, with out-of-range settings saturated.
  logic [bbs_pkg::WID_W-1:0] wl_eff, c_eff;
  logic [bbs_pkg::ROW_W-1:0] hl_eff, row_eff;
  logic                      in_acc, have_x, have_y;
  logic [bbs_pkg::WID_W-1:0] xlo_c, xhi_c;
  logic [bbs_pkg::ROW_W-1:0] ylo_c, yhi_c;
  logic                      k_in_w, k_in_h, dbit;

  assign in_acc = pix_i.valid && pix_i.ready;
  assign pix_i.ready = (state_q == bbs_pkg::ST_IDLE);

  always_comb begin
    if (width_q == '0) begin
      wl_eff = '0;
    end else if (32'(width_q) > MAX_WIDTH) begin
      wl_eff = bbs_pkg::WID_W'(MAX_WIDTH - 1);
    end else begin
      wl_eff = width_q - 1'b1;
    end
    hl_eff  = (height_q == '0) ? '0 : height_q - 1'b1;
    c_eff   = (col_q > wl_eff) ? wl_eff : col_q;
    row_eff = (row_q > hl_eff) ? hl_eff : row_q;

    // Columns whose horizontal window closes with this pixel.
    if (c_eff < wl_eff) begin
      have_x = (c_eff >= bbs_pkg::WID_W'(radius_q));
      xlo_c  = c_eff - bbs_pkg::WID_W'(radius_q);
      xhi_c  = xlo_c;
    end else begin
      have_x = 1'b1;
      xlo_c  = (c_eff >= bbs_pkg::WID_W'(radius_q)) ? c_eff - bbs_pkg::WID_W'(radius_q) : '0;
      xhi_c  = wl_eff;
    end
    // Rows whose vertical window closes with this row.
    if (row_eff < hl_eff) begin
      have_y = (row_eff >= bbs_pkg::ROW_W'(radius_q));
      ylo_c  = row_eff - bbs_pkg::ROW_W'(radius_q);
      yhi_c  = ylo_c;
    end else begin
      have_y = 1'b1;
      ylo_c  = (row_eff >= bbs_pkg::ROW_W'(radius_q)) ?
               row_eff - bbs_pkg::ROW_W'(radius_q) : '0;
      yhi_c  = hl_eff;
    end
  end

  assign k_in_w = !k_q[13] && (k_q[12:0] <= 13'(wl_q));
  assign k_in_h = !k_q[13] && (k_q[12:0] <= 13'(hl_q));
  assign dbit   = (acc_q >= div_q);

  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    r_cur_d     = r_cur_q;
    wl_d        = wl_q;
    hl_d        = hl_q;
    xlo_d       = xlo_q;
    xhi_d       = xhi_q;
    ylo_d       = ylo_q;
    yhi_d       = yhi_q;
    x_d         = x_q;
    y_d         = y_q;
    hslot_d     = hslot_q;
    have_y_d    = have_y_q;
    k_d         = k_q;
    kend_d      = kend_q;
    acc_d       = acc_q;
    div_d       = div_q;
    dcnt_d      = dcnt_q;
    quo_d       = quo_q;
    rd_pend_d   = 1'b0;
    res_load    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = st_addr(hslot_q, x_q);
    ram_raddr   = st_addr(bbs_pkg::mod15(k_q[11:0]), x_q);

    unique case (state_q)
      bbs_pkg::ST_IDLE: begin
        if (in_acc) begin
          r_cur_d  = radius_q;
          wl_d     = wl_eff;
          hl_d     = hl_eff;
          xlo_d    = xlo_c;
          xhi_d    = xhi_c;
          ylo_d    = ylo_c;
          yhi_d    = yhi_c;
          have_y_d = have_y;
          hslot_d  = bbs_pkg::mod15(row_eff);
          x_d      = xlo_c;
          k_d      = k_lo(12'(xlo_c), radius_q);
          kend_d   = k_hi(12'(xlo_c), radius_q);
          acc_d    = '0;
          if (c_eff == wl_eff) begin
            col_d = '0;
            row_d = (row_eff == hl_eff) ? '0 : row_eff + 1'b1;
          end else begin
            col_d = c_eff + 1'b1;
            row_d = row_eff;
          end
          if (have_x) begin
            state_d = bbs_pkg::ST_HSUM;
          end
        end
      end
      bbs_pkg::ST_HSUM: begin
        acc_d = acc_q + (k_in_w ? bbs_pkg::ACC_W'(win_q[bbs_pkg::mod15(k_q[11:0])]) : '0);
        if (k_q == kend_q) begin
          state_d = bbs_pkg::ST_HWR;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      bbs_pkg::ST_HWR: begin
        ram_we = 1'b1;
        acc_d  = '0;
        if (x_q == xhi_q) begin
          if (have_y_q) begin
            x_d     = xlo_q;
            y_d     = ylo_q;
            k_d     = k_lo(ylo_q, r_cur_q);
            kend_d  = k_hi(ylo_q, r_cur_q);
            state_d = bbs_pkg::ST_VRD;
          end else begin
            state_d = bbs_pkg::ST_IDLE;
          end
        end else begin
          x_d     = x_q + 1'b1;
          k_d     = k_lo(12'(x_q + 1'b1), r_cur_q);
          kend_d  = k_hi(12'(x_q + 1'b1), r_cur_q);
          state_d = bbs_pkg::ST_HSUM;
        end
      end
      bbs_pkg::ST_VRD: begin
        rd_pend_d = k_in_h;
        state_d   = bbs_pkg::ST_VADD;
      end
      bbs_pkg::ST_VADD: begin
        acc_d = acc_q + (rd_pend_q ? bbs_pkg::ACC_W'(ram_rdata) : '0);
        if (k_q == kend_q) begin
          div_d   = bbs_pkg::ACC_W'(bbs_pkg::area_of(r_cur_q)) << 7;
          dcnt_d  = 3'd7;
          quo_d   = '0;
          state_d = bbs_pkg::ST_DIV;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = bbs_pkg::ST_VRD;
        end
      end
      bbs_pkg::ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (dbit) begin
          acc_d = acc_q - div_q;
        end
        quo_d = {quo_q[6:0], dbit};
        div_d = div_q >> 1;
        if (dcnt_q == '0) begin
          state_d = bbs_pkg::ST_OUT;
        end else begin
          dcnt_d = dcnt_q - 1'b1;
        end
      end
      bbs_pkg::ST_OUT: begin
        if (!res_valid_q || res_o.ready) begin
          res_load = 1'b1;
          acc_d    = '0;
          if (x_q == xhi_q) begin
            if (y_q == yhi_q) begin
              state_d = bbs_pkg::ST_IDLE;
            end else begin
              x_d     = xlo_q;
              y_d     = y_q + 1'b1;
              k_d     = k_lo(y_q + 1'b1, r_cur_q);
              kend_d  = k_hi(y_q + 1'b1, r_cur_q);
              state_d = bbs_pkg::ST_VRD;
            end
          end else begin
            x_d     = x_q + 1'b1;
            k_d     = k_lo(y_q, r_cur_q);
            kend_d  = k_hi(y_q, r_cur_q);
            state_d = bbs_pkg::ST_VRD;
          end
        end
      end
      default: begin
        state_d = bbs_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_valid_d = res_load ? 1'b1 : (res_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= bbs_pkg::RAD_W'(1);
      width_q     <= bbs_pkg::WID_W'(640);
      height_q    <= bbs_pkg::HGT_W'(480);
      col_q       <= '0;
      row_q       <= '0;
      state_q     <= bbs_pkg::ST_IDLE;
      res_valid_q <= 1'b0;
      rd_pend_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bbs_pkg::CFG_RADIUS: radius_q <= cfg_wdata_i[bbs_pkg::RAD_W-1:0];
          bbs_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i[bbs_pkg::WID_W-1:0];
          bbs_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i[bbs_pkg::HGT_W-1:0];
          default: ;
        endcase
      end
      col_q       <= col_d;
      row_q       <= row_d;
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      rd_pend_q   <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_cur_q  <= r_cur_d;
    wl_q     <= wl_d;
    hl_q     <= hl_d;
    xlo_q    <= xlo_d;
    xhi_q    <= xhi_d;
    ylo_q    <= ylo_d;
    yhi_q    <= yhi_d;
    x_q      <= x_d;
    y_q      <= y_d;
    hslot_q  <= hslot_d;
    have_y_q <= have_y_d;
    k_q      <= k_d;
    kend_q   <= kend_d;
    acc_q    <= acc_d;
    div_q    <= div_d;
    dcnt_q   <= dcnt_d;
    quo_q    <= quo_d;
    if (in_acc) begin
      win_q[bbs_pkg::mod15(12'(c_eff))] <= pix_i.pixel_in;
    end
    if (res_load) begin
      res_pix_q <= quo_q;
      res_col_q <= x_q[bbs_pkg::COL_W-1:0];
      res_row_q <= y_q;
      res_rl_q  <= (x_q == xhi_q) && (y_q == yhi_q);
      res_fl_q  <= (x_q == wl_q) && (y_q == hl_q);
    end
  end

  bbs_ram #(
    .WIDTH (bbs_pkg::HSUM_W),
    .DEPTH (DEPTH)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (acc_q[bbs_pkg::HSUM_W-1:0]),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_o.valid      = res_valid_q;
  assign res_o.pixel_out  = res_pix_q;
  assign res_o.out_col    = res_col_q;
  assign res_o.out_row    = res_row_q;
  assign res_o.run_last   = res_rl_q;
  assign res_o.frame_last = res_fl_q;

  // A loaded result is presented on the next cycle.
  `BBS_ASSERT_NEXT(a_load_shows, res_load, res_valid_q, "loaded result not presented")
  // A pixel that closes no horizontal window leaves the block ready again.
  `BBS_ASSERT_NEXT(a_no_work_idle, in_acc && !have_x, state_q == bbs_pkg::ST_IDLE,
                   "pixel without work kept the block busy")
  // Results only appear out of the output state.
  `BBS_ASSERT_NOW(a_rise_from_out, $rose(res_valid_q), $past(state_q) == bbs_pkg::ST_OUT,
                  "result appeared outside the output state")

endmodule
`default_nettype wire
